>>> rtl/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Widths of the stream fields and the configuration word of the spanning tree
// engine.
// ----------------------------------------------------------------------------
package kms_pkg;

    localparam int CFG_W       = 5;   // node count register
    localparam int WEIGHT_W    = 16;  // weight field on both streams
    localparam int NODE_W      = 4;   // edge endpoint fields
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;  // node_a, node_b, edge_weight

endpackage

>>> rtl/kms_edge_ram.sv
// ----------------------------------------------------------------------------
// kms_edge_ram
// Simple dual-port store for the loaded edge weights: one write port, one
// read port with registered read data.
// ----------------------------------------------------------------------------
module kms_edge_ram #(
    parameter int DEPTH = 120,
    parameter int AW    = 7,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/kruskal_mst_engine.sv
// ----------------------------------------------------------------------------
// kruskal_mst_engine
// Loads the upper triangle of a complete graph's weights, then picks the
// minimum spanning tree edges in ascending (weight, load order) and streams
// them out, the final edge marked with tlast.
//
//   channel   direction  beat contents
//   s_axis    in         tdata[15:0] weight
//   m_axis    out        tdata[3:0] node_a, [7:4] node_b, [23:8] edge_weight;
//                        tlast last_edge
//   cfg       in         i_cfg_wdata node_count, written when i_cfg_we is high
//
// Load takes one beat per cycle. After the last weight the engine drops
// s_axis_tready; each Kruskal step scans every loaded edge through the store's
// single read port, then selects the cheapest candidate, walks the two parent
// chains, decides and, if the roots differ, emits the edge. A stalled m_axis
// holds the sequencer in its emit step. Reset is synchronous; the edge store
// needs no clearing.
// ----------------------------------------------------------------------------
module kruskal_mst_engine #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [15:0] weight

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] node_a, [7:4] node_b, [23:8] edge_weight
    output logic [kms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,

    input  logic                             i_cfg_we,
    input  logic [kms_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int MAX_EDGES  = MAX_NODES * (MAX_NODES - 1) / 2;
    localparam int AW         = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int TW         = $clog2(MAX_EDGES + 1);
    localparam int NW         = $clog2(MAX_NODES + 1);
    localparam int IW         = $clog2(MAX_NODES);
    localparam int SW         = (WEIGHT_BITS < kms_pkg::WEIGHT_W) ?
                                WEIGHT_BITS : kms_pkg::WEIGHT_W;
    localparam int CW         = (NW > kms_pkg::CFG_W) ? NW : kms_pkg::CFG_W;
    localparam int RST_NODES  = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int RST_TOTAL  = RST_NODES * (RST_NODES - 1) / 2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_END,
        ST_SEL,
        ST_FIND_A,
        ST_FIND_B,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    t_state          r_state;

    logic [NW-1:0]   r_nodes;
    logic [TW-1:0]   r_total;
    logic [TW-1:0]   r_load;
    logic [NW-1:0]   r_picked;

    // union-find store
    logic [IW-1:0]   r_parent [MAX_NODES];
    logic [2:0]      r_rank   [MAX_NODES];

    // scan address side
    logic [TW-1:0]   r_scan;
    logic [IW-1:0]   r_sa;
    logic [IW-1:0]   r_sb;
    // scan data side, aligned with the registered read data
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_idx;
    logic [IW-1:0]   r_rd_a;
    logic [IW-1:0]   r_rd_b;

    logic            r_have;
    logic [SW-1:0]   r_best_w;
    logic [AW-1:0]   r_best_idx;
    logic [IW-1:0]   r_best_a;
    logic [IW-1:0]   r_best_b;

    logic            r_first;
    logic [SW-1:0]   r_prev_w;
    logic [AW-1:0]   r_prev_idx;

    logic [IW-1:0]   r_x;
    logic [IW-1:0]   r_ra;
    logic [IW-1:0]   r_rb;
    logic [2:0]      r_rka;
    logic [2:0]      r_rkb;

    logic                          r_out_vld;
    logic [kms_pkg::NODE_W-1:0]    r_out_a;
    logic [kms_pkg::NODE_W-1:0]    r_out_b;
    logic [kms_pkg::WEIGHT_W-1:0]  r_out_w;
    logic                          r_out_last;

    logic [CW-1:0]   cfg_ext;
    logic [NW-1:0]   n_nodes;
    logic [2*NW-1:0] n_pairs;
    logic [TW-1:0]   n_total;

    logic [SW-1:0]   rd_w;
    logic            ram_we;
    logic            in_beat;
    logic            cand_ok;
    logic            cand_better;
    logic            out_free;
    logic            pick_last;
    logic            scan_wrap;
    logic [IW-1:0]   par_x;

    // clamp the written node count and work out the edge total
    always_comb begin
        cfg_ext = CW'(i_cfg_wdata);
        if (cfg_ext < CW'(2)) begin
            n_nodes = NW'(2);
        end else if (cfg_ext > CW'(MAX_NODES)) begin
            n_nodes = NW'(MAX_NODES);
        end else begin
            n_nodes = NW'(cfg_ext);
        end
        n_pairs = (2*NW)'(n_nodes) * (2*NW)'(n_nodes - NW'(1));
        n_total = TW'(n_pairs >> 1);
    end

    assign in_beat  = s_axis_tvalid && (r_state == ST_LOAD);
    assign ram_we   = in_beat;
    assign out_free = !r_out_vld || m_axis_tready;
    assign pick_last = (NW'(r_picked + NW'(1)) == NW'(r_nodes - NW'(1)));
    assign scan_wrap = (NW'(r_sb) == NW'(r_nodes - NW'(1)));
    assign par_x     = r_parent[r_x];

    kms_edge_ram #(
        .DEPTH (MAX_EDGES),
        .AW    (AW),
        .DW    (SW)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load[AW-1:0]),
        .i_wdata (s_axis_tdata[SW-1:0]),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (rd_w)
    );

    // next edge in (weight, load order) after the last one examined
    assign cand_ok = r_first || (rd_w > r_prev_w) ||
                     ((rd_w == r_prev_w) && (r_rd_idx > r_prev_idx));
    assign cand_better = !r_have || (rd_w < r_best_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_nodes    <= NW'(RST_NODES);
            r_total    <= TW'(RST_TOTAL);
            r_load     <= '0;
            r_picked   <= '0;
            r_rd_vld   <= 1'b0;
            r_have     <= 1'b0;
            r_first    <= 1'b1;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_out_vld && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            if (i_cfg_we) begin
                r_nodes <= n_nodes;
                r_total <= n_total;
                r_load  <= '0;
            end

            r_rd_vld <= 1'b0;
            if (r_rd_vld && cand_ok && cand_better) begin
                r_have     <= 1'b1;
                r_best_w   <= rd_w;
                r_best_idx <= r_rd_idx;
                r_best_a   <= r_rd_a;
                r_best_b   <= r_rd_b;
            end

            case (r_state)
                ST_LOAD: begin
                    if (in_beat) begin
                        if (r_load + TW'(1) == r_total) begin
                            r_load   <= '0;
                            r_picked <= '0;
                            r_first  <= 1'b1;
                            r_have   <= 1'b0;
                            r_scan   <= '0;
                            r_sa     <= '0;
                            r_sb     <= IW'(1);
                            for (int i = 0; i < MAX_NODES; i++) begin
                                r_parent[i] <= IW'(i);
                                r_rank[i]   <= '0;
                            end
                            r_state  <= ST_SCAN;
                        end else begin
                            r_load <= r_load + TW'(1);
                        end
                    end
                end
                ST_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_rd_idx <= r_scan[AW-1:0];
                    r_rd_a   <= r_sa;
                    r_rd_b   <= r_sb;
                    r_scan   <= r_scan + TW'(1);
                    if (scan_wrap) begin
                        r_sa <= r_sa + IW'(1);
                        r_sb <= r_sa + IW'(2);
                    end else begin
                        r_sb <= r_sb + IW'(1);
                    end
                    if (r_scan == r_total - TW'(1)) begin
                        r_state <= ST_SCAN_END;
                    end
                end
                ST_SCAN_END: begin
                    // last read data is compared this cycle
                    r_state <= ST_SEL;
                end
                ST_SEL: begin
                    r_x     <= r_best_a;
                    r_state <= ST_FIND_A;
                end
                ST_FIND_A: begin
                    if (par_x == r_x) begin
                        r_ra    <= r_x;
                        r_rka   <= r_rank[r_x];
                        r_x     <= r_best_b;
                        r_state <= ST_FIND_B;
                    end else begin
                        r_x <= par_x;
                    end
                end
                ST_FIND_B: begin
                    if (par_x == r_x) begin
                        r_rb    <= r_x;
                        r_rkb   <= r_rank[r_x];
                        r_state <= ST_DECIDE;
                    end else begin
                        r_x <= par_x;
                    end
                end
                ST_DECIDE: begin
                    r_first    <= 1'b0;
                    r_prev_w   <= r_best_w;
                    r_prev_idx <= r_best_idx;
                    if (r_ra != r_rb) begin
                        // union by rank
                        if (r_rka >= r_rkb) begin
                            r_parent[r_rb] <= r_ra;
                            if (r_rka == r_rkb) begin
                                r_rank[r_ra] <= r_rka + 3'd1;
                            end
                        end else begin
                            r_parent[r_ra] <= r_rb;
                        end
                        r_state <= ST_EMIT;
                    end else begin
                        r_have  <= 1'b0;
                        r_scan  <= '0;
                        r_sa    <= '0;
                        r_sb    <= IW'(1);
                        r_state <= ST_SCAN;
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_a    <= kms_pkg::NODE_W'(r_best_a);
                        r_out_b    <= kms_pkg::NODE_W'(r_best_b);
                        r_out_w    <= kms_pkg::WEIGHT_W'(r_best_w);
                        r_out_last <= pick_last;
                        r_picked   <= r_picked + NW'(1);
                        if (pick_last) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_have  <= 1'b0;
                            r_scan  <= '0;
                            r_sa    <= '0;
                            r_sb    <= IW'(1);
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_w, r_out_b, r_out_a};
    assign m_axis_tlast  = r_out_last;

    a_find_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIND_A || r_state == ST_FIND_B) |-> (NW'(r_x) < r_nodes))
        else $error("union-find walk left the node range");

    a_load_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load < r_total)
        else $error("load counter reached the edge total");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_EMIT))
        else $error("output beat raised outside the emit step");

    a_picks_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (NW'(r_picked + NW'(1)) < r_nodes))
        else $error("more edges picked than the tree holds");

endmodule
